// ----- design/obb_overlap_test_2d_defines.svh -----
// Assertion macros for the obb_overlap_test_2d block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef OBB_OVERLAP_TEST_2D_DEFINES_SVH
`define OBB_OVERLAP_TEST_2D_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OBB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("obb assertion failed");

// Next-cycle implication, checked out of reset.
`define OBB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("obb assertion failed");

`endif

// ----- design/obb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the box overlap test.
// Holds the sine table generator used at elaboration; no dependencies.
package obb_pkg;

	localparam int unsigned SIZE_BITS   = 12;
	localparam int unsigned ANGLE_BITS  = 9;
	localparam int unsigned RIGHT_ANGLE = 90;
	localparam int unsigned HALF_TURN   = 180;
	localparam int unsigned THREE_QTR   = 270;
	localparam int unsigned FULL_TURN   = 360;
	localparam int unsigned QTR_ENTRIES = 91;
	localparam int unsigned AXIS_COUNT  = 4;
	localparam logic [63:0] PI_Q28      = 64'd843314857;

	// Taylor series divisors (2k)(2k+1), k = 1..8
	localparam logic [63:0] SERIES_DIV [1:8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// Load enables for the stages held in each axis unit
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// sin(deg) for deg in 0..90, series in Q28, rounded half up to frac bits.
	// Only called with constant arguments to build the table.
	function automatic logic [31:0] sin_quadrant_q(input int unsigned deg,
		input int unsigned frac);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] acc;
		x    = (64'(deg) * PI_Q28 + 64'd90) / 64'd180;
		x2   = (x * x) >> 28;
		term = x;
		acc  = $signed(x);
		for (int k = 1; k <= 8; k++) begin
			term = (term * x2) >> 28;
			term = term / SERIES_DIV[k];
			if (k % 2 == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = '0;
		end
		return 32'((64'(acc) + (64'd1 << (27 - frac))) >> (28 - frac));
	endfunction

endpackage

// ----- design/obb_req_if.sv -----
`timescale 1ns / 1ps
// Input channel: one pair of rotated boxes per transfer.
// Standalone interface; no package dependency.
interface obb_req_if #(
	parameter int COORD_BITS = 16
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_left;
	logic signed [COORD_BITS-1:0] a_top;
	logic [11:0]                  a_width;
	logic [11:0]                  a_height;
	logic [8:0]                   a_angle;
	logic signed [COORD_BITS-1:0] b_left;
	logic signed [COORD_BITS-1:0] b_top;
	logic [11:0]                  b_width;
	logic [11:0]                  b_height;
	logic [8:0]                   b_angle;

	modport source (
		output valid, a_left, a_top, a_width, a_height, a_angle,
		output b_left, b_top, b_width, b_height, b_angle,
		input  ready
	);
	modport sink (
		input  valid, a_left, a_top, a_width, a_height, a_angle,
		input  b_left, b_top, b_width, b_height, b_angle,
		output ready
	);
endinterface

// ----- design/obb_rsp_if.sv -----
`timescale 1ns / 1ps
// Output channel: one overlap flag per transfer.
// Standalone interface; no package dependency.
interface obb_rsp_if ();
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink (input valid, overlap, output ready);
endinterface

// ----- design/obb_trig.sv -----
`timescale 1ns / 1ps
// Angle reduction and sine/cosine lookup in Q1.F from a quarter-wave table.
// Depends on obb_pkg for the table generator and angle constants.
module obb_trig #(
	parameter int F = 14
) (
	input  logic [8:0]        angle,
	output logic signed [F+1:0] sin_v,
	output logic signed [F+1:0] cos_v
);
	import obb_pkg::*;

	logic [F:0] rom [QTR_ENTRIES];

	for (genvar d = 0; d < QTR_ENTRIES; d++) begin : g_rom
		localparam logic [F:0] ENTRY = (F+1)'(sin_quadrant_q(d, F));
		assign rom[d] = ENTRY;
	end

	// Fold a reduced angle onto the first quadrant: {negate, index}
	function automatic logic [7:0] quad_map(input logic [8:0] v);
		logic       n;
		logic [8:0] i;
		if (v <= 9'(RIGHT_ANGLE)) begin
			n = 1'b0;
			i = v;
		end else if (v <= 9'(HALF_TURN)) begin
			n = 1'b0;
			i = 9'(HALF_TURN) - v;
		end else if (v <= 9'(THREE_QTR)) begin
			n = 1'b1;
			i = v - 9'(HALF_TURN);
		end else begin
			n = 1'b1;
			i = 9'(FULL_TURN) - v;
		end
		return {n, i[6:0]};
	endfunction

	logic [8:0] ang_red;
	logic [9:0] cos_arg;
	logic [8:0] cos_red;
	logic [7:0] s_map;
	logic [7:0] c_map;
	logic signed [F+1:0] s_mag;
	logic signed [F+1:0] c_mag;

	always_comb begin
		ang_red = (angle >= 9'(FULL_TURN)) ? angle - 9'(FULL_TURN) : angle;
		cos_arg = {1'b0, ang_red} + 10'(RIGHT_ANGLE);
		if (cos_arg >= 10'(FULL_TURN)) begin
			cos_red = 9'(cos_arg - 10'(FULL_TURN));
		end else begin
			cos_red = cos_arg[8:0];
		end
		s_map = quad_map(ang_red);
		c_map = quad_map(cos_red);
		s_mag = $signed({1'b0, rom[s_map[6:0]]});
		c_mag = $signed({1'b0, rom[c_map[6:0]]});
		sin_v = s_map[7] ? -s_mag : s_mag;
		cos_v = c_map[7] ? -c_mag : c_mag;
	end
endmodule

// ----- design/obb_axis.sv -----
`timescale 1ns / 1ps
// One separating axis: projections (s2), size scaling and magnitudes (s3),
// reach sum and compare (s4). Depends on obb_pkg for stage_en_t.
module obb_axis #(
	parameter int F   = 14,
	parameter int DW  = 19,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  obb_pkg::stage_en_t  en,
	input  logic signed [F+1:0] ux_s1 [4],
	input  logic signed [F+1:0] uy_s1 [4],
	input  logic [11:0]         size_s1 [4],
	input  logic signed [DW-1:0] dx_s1,
	input  logic signed [DW-1:0] dy_s1,
	output logic                sep_s4
);
	import obb_pkg::*;

	localparam int T  = F + 2;
	localparam int DP = 2*F + 4;
	localparam int SP = DP + SIZE_BITS + 1;
	localparam int RW = SP - 1;
	localparam int GP = DW + T + 1;
	localparam int CW = ((GP + F > RW + 2) ? GP + F : RW + 2) + 1;

	logic signed [DP-1:0] dot_s2 [4];
	logic [11:0]          size_s2 [4];
	logic signed [GP-1:0] gap_s2;
	logic [RW-1:0]        reach_s3 [4];
	logic [GP-1:0]        gap_s3;

	logic signed [DP-1:0] dot_c [4];
	logic signed [GP-1:0] gap_c;
	logic signed [SP-1:0] term_c [4];
	logic [CW-1:0]        sum_c;
	logic [CW-1:0]        gap_sh_c;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			dot_c[j] = DP'(ux_s1[j]) * DP'(ux_s1[IDX]) + DP'(uy_s1[j]) * DP'(uy_s1[IDX]);
		end
		gap_c = GP'(dx_s1) * GP'(ux_s1[IDX]) + GP'(dy_s1) * GP'(uy_s1[IDX]);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			dot_s2  <= dot_c;
			size_s2 <= size_s1;
			gap_s2  <= gap_c;
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			term_c[j] = SP'($signed({1'b0, size_s2[j]})) * SP'(dot_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int j = 0; j < 4; j++) begin
				reach_s3[j] <= term_c[j][SP-1] ? RW'(-term_c[j]) : RW'(term_c[j]);
			end
			gap_s3 <= gap_s2[GP-1] ? GP'(-gap_s2) : GP'(gap_s2);
		end
	end

	always_comb begin
		sum_c = '0;
		for (int j = 0; j < 4; j++) begin
			sum_c = sum_c + CW'(reach_s3[j]);
		end
		gap_sh_c = CW'(gap_s3) << F;
	end

	// Equality is touching, not separated
	always_ff @(posedge clk) begin
		if (en.s4) begin
			sep_s4 <= gap_sh_c > sum_c;
		end
	end
endmodule

// ----- design/obb_overlap_test_2d.sv -----
`timescale 1ns / 1ps
// Top level of the rotated box overlap test (separating axis test, 2D).
// Depends on obb_pkg, obb_req_if, obb_rsp_if, obb_trig, obb_axis and the defines header.
//
// Takes one box pair per cycle unless the pipeline is full, and returns one
// overlap flag per pair, in order. Each result waits in the output register
// until the output side is ready. The five registers are table lookup and center
// difference (loaded at the accepting edge), axis projections, size scaling,
// reach sum and compare, then the output register.
// Stages that hold no item keep taking input while a result waits, so stalls cost
// nothing until the pipeline is full. Angles of 360 and above wrap; touching boxes
// count as overlap.
module obb_overlap_test_2d #(
	parameter int COORD_BITS         = 16,
	parameter int TRIG_FRACTION_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	obb_req_if.sink   req,
	obb_rsp_if.source rsp
);
	import obb_pkg::*;
	`include "obb_overlap_test_2d_defines.svh"

	localparam int F  = TRIG_FRACTION_BITS;
	localparam int T  = F + 2;
	localparam int C  = COORD_BITS;
	localparam int DW = ((C + 1 > SIZE_BITS + 1) ? C + 1 : SIZE_BITS + 1) + 2;

	logic signed [T-1:0] sa_c, ca_c, sb_c, cb_c;
	logic signed [DW-1:0] dx_c, dy_c;

	logic signed [T-1:0]  ux_s1 [4];
	logic signed [T-1:0]  uy_s1 [4];
	logic [11:0]          size_s1 [4];
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [3:0]           sep_s4;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rsp_valid_q, overlap_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_o;
	stage_en_t en;

	obb_trig #(.F(F)) u_trig_a (.angle(req.a_angle), .sin_v(sa_c), .cos_v(ca_c));
	obb_trig #(.F(F)) u_trig_b (.angle(req.b_angle), .sin_v(sb_c), .cos_v(cb_c));

	// Doubled centers: 2*left + width, so no half pixels appear
	always_comb begin
		dx_c = ($signed(DW'(req.a_left)) <<< 1) + $signed(DW'(req.a_width))
			- ($signed(DW'(req.b_left)) <<< 1) - $signed(DW'(req.b_width));
		dy_c = ($signed(DW'(req.a_top)) <<< 1) + $signed(DW'(req.a_height))
			- ($signed(DW'(req.b_top)) <<< 1) - $signed(DW'(req.b_height));
	end

	// Each stage advances when empty or when the next one advances
	always_comb begin
		rdy_o = !rsp_valid_q || rsp.ready;
		rdy4  = !valid_s4 || rdy_o;
		rdy3  = !valid_s3 || rdy4;
		rdy2  = !valid_s2 || rdy3;
		rdy1  = !valid_s1 || rdy2;
		en.s2 = rdy2;
		en.s3 = rdy3;
		en.s4 = rdy4;
	end

	assign req.ready   = rdy1;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.overlap = overlap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= req.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy_o) rsp_valid_q <= valid_s4;
		end
	end

	// Axis order: height A, height B, width A, width B
	always_ff @(posedge clk) begin
		if (rdy1) begin
			ux_s1[0]   <= sa_c;
			uy_s1[0]   <= -ca_c;
			ux_s1[1]   <= sb_c;
			uy_s1[1]   <= -cb_c;
			ux_s1[2]   <= ca_c;
			uy_s1[2]   <= sa_c;
			ux_s1[3]   <= cb_c;
			uy_s1[3]   <= sb_c;
			size_s1[0] <= req.a_height;
			size_s1[1] <= req.b_height;
			size_s1[2] <= req.a_width;
			size_s1[3] <= req.b_width;
			dx_s1      <= dx_c;
			dy_s1      <= dy_c;
		end
	end

	for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_axis
		obb_axis #(.F(F), .DW(DW), .IDX(i)) u_axis (
			.clk     (clk),
			.en      (en),
			.ux_s1   (ux_s1),
			.uy_s1   (uy_s1),
			.size_s1 (size_s1),
			.dx_s1   (dx_s1),
			.dy_s1   (dy_s1),
			.sep_s4  (sep_s4[i])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy_o && valid_s4) begin
			overlap_q <= ~|sep_s4;
		end
	end

	`OBB_ASSERT_IMP(a_full_when_blocked, !req.ready,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && rsp_valid_q)
	`OBB_ASSERT_NXT(a_s1_moves_on, valid_s1 && rdy2, valid_s2)
	`OBB_ASSERT_NXT(a_result_held, rsp_valid_q && !rsp.ready,
		rsp_valid_q && $stable(overlap_q))
endmodule
